@@ src/rle8_pkg.sv @@
// ----------------------------------------------------------------------------
// RLE8 decoder package
// Types and constants shared by the bitmap RLE8 line decoder.
// ----------------------------------------------------------------------------
package rle8_pkg;

  localparam int MAX_LINE = 4096;
  localparam int POS_W    = 12;

  localparam logic [POS_W-1:0] COL_MAX   = POS_W'(MAX_LINE - 1);
  localparam logic [POS_W-1:0] ROW_MAX   = POS_W'(MAX_LINE - 1);
  localparam logic [POS_W-1:0] MIN_WIDTH = POS_W'(16);

  localparam logic [7:0] ESC_EOL   = 8'h00;
  localparam logic [7:0] ESC_EOB   = 8'h01;
  localparam logic [7:0] ESC_DELTA = 8'h02;

  localparam logic [1:0] KIND_RUN     = 2'd0;
  localparam logic [1:0] KIND_LITERAL = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_COLOR   = 3'd1,
    PH_ESCAPE  = 3'd2,
    PH_LITERAL = 3'd3,
    PH_PAD     = 3'd4,
    PH_DX      = 3'd5,
    PH_DY      = 3'd6
  } phase_t;

endpackage

@@ src/bmp_rle8_line_decoder.sv @@
// ----------------------------------------------------------------------------
// Bitmap RLE8 line decoder
// Parses an RLE8 code stream one byte per item and emits run segments,
// literal pixels and an end-of-bitmap marker with their row and column.
// ----------------------------------------------------------------------------
// The decoder takes one code byte per cycle. Each byte is decoded by the
// parse state and the current position in the same cycle and its result is
// loaded into the output register, so a new byte is accepted in the cycle in
// which the previous result is taken. A run byte whose run crosses
// the end of one or more rows gives one segment per row touched; after the
// first segment the input is held while the row-wrap unit produces the
// remaining segments, one per cycle when the output is not stalled.
// Backpressure on the output stalls the input.
module bmp_rle8_line_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,   // pixels per row
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,       // code_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,       // row[11:0], column[23:12], length[31:24],
                                     // color_index[39:32]
  output logic [1:0]  m_tuser,       // kind
  output logic        m_tlast        // last
);
  import rle8_pkg::*;

  logic [POS_W-1:0] row_width;
  phase_t           phase, phase_next;
  logic [7:0]       held_count, held_count_next;
  logic [7:0]       literal_left, literal_left_next;
  logic             pad_pending, pad_pending_next;
  logic [POS_W-1:0] cur_column, cur_column_next;
  logic [POS_W-1:0] cur_row, cur_row_next;
  logic [7:0]       held_dx, held_dx_next;
  logic             finished, finished_next;
  logic             draining, draining_next;
  logic [7:0]       run_left, run_left_next;
  logic [7:0]       run_color, run_color_next;

  logic [POS_W-1:0] row_q, column_q;
  logic [7:0]       length_q, color_q;
  logic [1:0]       kind_q;
  logic             last_q;

  logic             out_free, accept;
  logic             emit;
  logic [1:0]       emit_kind;
  logic [POS_W-1:0] emit_row, emit_column;
  logic [7:0]       emit_length, emit_color;
  logic             emit_last;

  logic [POS_W-1:0] width_eff;
  logic [7:0]       draw_want;
  logic             wrap0, wrap1;
  logic [POS_W-1:0] draw_col0, draw_row0, draw_room;
  logic [7:0]       draw_len;
  logic [POS_W:0]   draw_col1;
  logic [POS_W-1:0] draw_col_after, draw_row_after;
  logic [7:0]       run_rem;
  logic [POS_W:0]   delta_col, delta_row;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !draining && out_free;
  assign accept   = s_tvalid && s_tready;

  // Row-wrap unit: one segment of up to draw_want pixels.
  assign width_eff = (row_width < MIN_WIDTH) ? MIN_WIDTH : row_width;
  assign draw_want = draining ? run_left : ((phase == PH_COLOR) ? held_count : 8'd1);
  assign wrap0     = cur_column >= width_eff;
  assign draw_col0 = wrap0 ? '0 : cur_column;
  assign draw_row0 = (wrap0 && cur_row != ROW_MAX) ? cur_row + POS_W'(1) : cur_row;
  assign draw_room = width_eff - draw_col0;
  assign draw_len  = (draw_room < {4'd0, draw_want}) ? draw_room[7:0] : draw_want;
  assign draw_col1 = {1'b0, draw_col0} + {5'd0, draw_len};
  assign wrap1     = draw_col1 >= {1'b0, width_eff};
  assign draw_col_after = wrap1 ? '0 : draw_col1[POS_W-1:0];
  assign draw_row_after = (wrap1 && draw_row0 != ROW_MAX) ? draw_row0 + POS_W'(1)
                                                          : draw_row0;
  assign run_rem   = draw_want - draw_len;

  assign delta_col = {1'b0, cur_column} + {5'd0, held_dx};
  assign delta_row = {1'b0, cur_row} + {5'd0, s_tdata};

  always_comb begin
    phase_next        = phase;
    held_count_next   = held_count;
    literal_left_next = literal_left;
    pad_pending_next  = pad_pending;
    cur_column_next   = cur_column;
    cur_row_next      = cur_row;
    held_dx_next      = held_dx;
    finished_next     = finished;
    draining_next     = draining;
    run_left_next     = run_left;
    run_color_next    = run_color;
    emit        = 1'b0;
    emit_kind   = KIND_RUN;
    emit_row    = draw_row0;
    emit_column = draw_col0;
    emit_length = draw_len;
    emit_color  = draining ? run_color : s_tdata;
    emit_last   = 1'b1;

    if (draining) begin
      if (out_free) begin
        emit            = 1'b1;
        emit_last       = (run_rem == 8'd0);
        cur_column_next = draw_col_after;
        cur_row_next    = draw_row_after;
        run_left_next   = run_rem;
        draining_next   = (run_rem != 8'd0);
      end
    end else if (accept && !finished) begin
      unique case (phase)
        PH_FIRST: begin
          if (s_tdata != ESC_EOL) begin
            held_count_next = s_tdata;
            phase_next      = PH_COLOR;
          end else begin
            phase_next = PH_ESCAPE;
          end
        end
        PH_COLOR: begin
          emit            = 1'b1;
          emit_last       = (run_rem == 8'd0);
          cur_column_next = draw_col_after;
          cur_row_next    = draw_row_after;
          run_left_next   = run_rem;
          run_color_next  = s_tdata;
          draining_next   = (run_rem != 8'd0);
          held_count_next = 8'd0;
          phase_next      = PH_FIRST;
        end
        PH_ESCAPE: begin
          unique case (s_tdata)
            ESC_EOL: begin
              if (cur_column != '0) begin
                cur_column_next = '0;
                if (cur_row != ROW_MAX) begin
                  cur_row_next = cur_row + POS_W'(1);
                end
              end
              phase_next = PH_FIRST;
            end
            ESC_EOB: begin
              emit          = 1'b1;
              emit_kind     = KIND_END;
              emit_row      = cur_row;
              emit_column   = cur_column;
              emit_length   = 8'd0;
              emit_color    = 8'd0;
              finished_next = 1'b1;
              phase_next    = PH_FIRST;
            end
            ESC_DELTA: begin
              phase_next = PH_DX;
            end
            default: begin
              literal_left_next = s_tdata;
              pad_pending_next  = s_tdata[0];
              phase_next        = PH_LITERAL;
            end
          endcase
        end
        PH_LITERAL: begin
          emit            = 1'b1;
          emit_kind       = KIND_LITERAL;
          cur_column_next = draw_col_after;
          cur_row_next    = draw_row_after;
          if (literal_left <= 8'd1) begin
            literal_left_next = 8'd0;
            phase_next        = pad_pending ? PH_PAD : PH_FIRST;
          end else begin
            literal_left_next = literal_left - 8'd1;
          end
        end
        PH_PAD: begin
          pad_pending_next = 1'b0;
          phase_next       = PH_FIRST;
        end
        PH_DX: begin
          held_dx_next = s_tdata;
          phase_next   = PH_DY;
        end
        PH_DY: begin
          cur_column_next = (delta_col > {1'b0, COL_MAX}) ? COL_MAX
                                                           : delta_col[POS_W-1:0];
          cur_row_next    = (delta_row > {1'b0, ROW_MAX}) ? ROW_MAX
                                                           : delta_row[POS_W-1:0];
          held_dx_next    = 8'd0;
          phase_next      = PH_FIRST;
        end
        default: begin
          phase_next = PH_FIRST;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width    <= POS_W'(480);
      phase        <= PH_FIRST;
      held_count   <= 8'd0;
      literal_left <= 8'd0;
      pad_pending  <= 1'b0;
      cur_column   <= '0;
      cur_row      <= '0;
      held_dx      <= 8'd0;
      finished     <= 1'b0;
      draining     <= 1'b0;
      run_left     <= 8'd0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        row_width <= cfg_wr_data;
      end
      phase        <= phase_next;
      held_count   <= held_count_next;
      literal_left <= literal_left_next;
      pad_pending  <= pad_pending_next;
      cur_column   <= cur_column_next;
      cur_row      <= cur_row_next;
      held_dx      <= held_dx_next;
      finished     <= finished_next;
      draining     <= draining_next;
      run_left     <= run_left_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    run_color <= run_color_next;
    if (emit) begin
      kind_q   <= emit_kind;
      row_q    <= emit_row;
      column_q <= emit_column;
      length_q <= emit_length;
      color_q  <= emit_color;
      last_q   <= emit_last;
    end
  end

  assign m_tdata = {color_q, length_q, column_q, row_q};
  assign m_tuser = kind_q;
  assign m_tlast = last_q;

endmodule

@@ test/bmp_rle8_line_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// Bitmap RLE8 line decoder testbench
// Feeds RLE8 code bytes through the stream input and compares every emitted
// segment with a behavioral decoder in the bench, or with the segment given
// in a row of the short opening table, which covers the basic escapes.
// Random phases follow across several line widths, with random idle cycles
// on both sides (none in one phase) and one long output hold-off.
// ----------------------------------------------------------------------------
module bmp_rle8_line_decoder_tb;
  import rle8_pkg::*;

  localparam logic [7:0]  ESC_INTRO        = 8'h00;
  localparam logic [11:0] ROW_WIDTH_RESET  = 12'd480;
  localparam int          IDLE_PCT         = 23;
  localparam int          SETTLE_CYCLES    = 24;
  localparam int          HOLD_CYCLES      = 300;
  localparam int          PHASE_ITEMS      = 50;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] row;
    logic [11:0] column;
    logic [7:0]  length;
    logic [7:0]  color_index;
    logic        last;
  } segment_t;

  typedef struct packed {
    logic [7:0] code;
    logic       typed;
    segment_t   seg;
  } opening_row_t;

  localparam opening_row_t OPENING_ROWS [26] = '{
    '{8'h05, 1'b0, '0},
    '{8'hAA, 1'b1, '{KIND_RUN, 12'd0, 12'd0, 8'd5, 8'hAA, 1'b1}},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_RUN, 12'd0, 12'd5, 8'd255, 8'h00, 1'b1}},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h03, 1'b0, '0},
    '{8'h11, 1'b1, '{KIND_LITERAL, 12'd1, 12'd0, 8'd1, 8'h11, 1'b1}},
    '{8'h22, 1'b0, '0},
    '{8'h33, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h02, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h04, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'hFE, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'hFF, 1'b0, '0}
  };

  localparam logic [11:0] PHASE_WIDTHS [6] = '{
    12'd16, 12'd4095, 12'd0, 12'd480, 12'd0, 12'd15
  };

  logic        clk;
  logic        rst         = 1'b1;
  logic        cfg_wr_en   = 1'b0;
  logic [11:0] cfg_wr_data = '0;
  logic        s_tvalid    = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata     = '0;
  logic        m_tvalid;
  logic        m_tready    = 1'b0;
  logic [39:0] m_tdata;        // row[11:0], column[23:12], length[31:24],
                               // color_index[39:32]
  logic [1:0]  m_tuser;        // kind
  logic        m_tlast;

  phase_t      ph;
  logic [7:0]  held_count;
  logic [7:0]  literal_left;
  logic        pad_pending;
  logic [11:0] cur_column;
  logic [11:0] cur_row;
  logic [7:0]  held_dx;
  logic        finished;
  logic [11:0] line_w;

  segment_t    step_segments [$];
  segment_t    pending_segments [$];

  int fails         = 0;
  int idle_pct      = IDLE_PCT;
  int hold_requests = 0;
  int hold_served   = 0;
  int random_sent   = 0;

  bmp_rle8_line_decoder i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("** bmp_rle8_line_decoder: FAILED **");
    $finish;
  end

  function automatic void advance_row();
    cur_column = '0;
    if (cur_row < ROW_MAX) begin
      cur_row = cur_row + 12'd1;
    end
  endfunction

  function automatic segment_t segment_here(logic [1:0] kind, logic [7:0] length,
                                            logic [7:0] color);
    segment_t seg;
    seg.kind        = kind;
    seg.row         = cur_row;
    seg.column      = cur_column;
    seg.length      = length;
    seg.color_index = color;
    seg.last        = 1'b0;
    return seg;
  endfunction

  // Draws one segment of at most want pixels, wrapping at the line width.
  function automatic logic [7:0] draw_pixels(logic [1:0] kind, logic [7:0] want,
                                             logic [7:0] color);
    logic [11:0] w;
    logic [11:0] span;
    w = (line_w < MIN_WIDTH) ? MIN_WIDTH : line_w;
    if (cur_column >= w) begin
      advance_row();
    end
    span = w - cur_column;
    if (span > {4'd0, want}) begin
      span = {4'd0, want};
    end
    step_segments.push_back(segment_here(kind, span[7:0], color));
    cur_column = cur_column + span;
    if (cur_column >= w) begin
      advance_row();
    end
    return span[7:0];
  endfunction

  function automatic void decode_code_byte(logic [7:0] b);
    logic [7:0]  remaining;
    logic [12:0] sum;
    step_segments.delete();
    if (!finished) begin
      case (ph)
        PH_FIRST: begin
          if (b != ESC_INTRO) begin
            held_count = b;
            ph = PH_COLOR;
          end else begin
            ph = PH_ESCAPE;
          end
        end
        PH_COLOR: begin
          remaining = held_count;
          while (remaining != 0) begin
            remaining = remaining - draw_pixels(KIND_RUN, remaining, b);
          end
          held_count = '0;
          ph = PH_FIRST;
        end
        PH_ESCAPE: begin
          if (b == ESC_EOL) begin
            if (cur_column != 0) begin
              advance_row();
            end
            ph = PH_FIRST;
          end else if (b == ESC_EOB) begin
            step_segments.push_back(segment_here(KIND_END, 8'd0, 8'd0));
            finished = 1'b1;
            ph = PH_FIRST;
          end else if (b == ESC_DELTA) begin
            ph = PH_DX;
          end else begin
            literal_left = b;
            pad_pending = b[0];
            ph = PH_LITERAL;
          end
        end
        PH_LITERAL: begin
          void'(draw_pixels(KIND_LITERAL, 8'd1, b));
          if (literal_left != 0) begin
            literal_left = literal_left - 8'd1;
          end
          if (literal_left == 0) begin
            ph = pad_pending ? PH_PAD : PH_FIRST;
          end
        end
        PH_PAD: begin
          pad_pending = 1'b0;
          ph = PH_FIRST;
        end
        PH_DX: begin
          held_dx = b;
          ph = PH_DY;
        end
        PH_DY: begin
          sum = {1'b0, cur_column} + {5'd0, held_dx};
          cur_column = (sum > {1'b0, COL_MAX}) ? COL_MAX : sum[11:0];
          sum = {1'b0, cur_row} + {5'd0, b};
          cur_row = (sum > {1'b0, ROW_MAX}) ? ROW_MAX : sum[11:0];
          held_dx = '0;
          ph = PH_FIRST;
        end
        default: begin
          ph = PH_FIRST;
        end
      endcase
      if (step_segments.size() != 0) begin
        step_segments[step_segments.size() - 1].last = 1'b1;
      end
    end
  endfunction

  task automatic send_code(input logic [7:0] code, input logic typed, input segment_t seg);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    decode_code_byte(code);
    if (typed) begin
      pending_segments.push_back(seg);
    end else begin
      foreach (step_segments[i]) begin
        pending_segments.push_back(step_segments[i]);
      end
    end
  endtask

  // The end of bitmap is kept for the close of the run.
  task automatic send_random(input logic [7:0] code);
    logic [7:0] b;
    b = code;
    if (ph == PH_ESCAPE && b == ESC_EOB) begin
      b = ESC_EOL;
    end
    send_code(b, 1'b0, '0);
    random_sent++;
  endtask

  task automatic send_sequence();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_random(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255)));
      send_random(8'($urandom_range(0, 255)));
    end else if (pick < 60) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 10);
      send_random(ESC_INTRO);
      send_random(8'(n));
      for (int k = 0; k < n; k++) begin
        send_random(8'($urandom_range(0, 255)));
      end
      if (n % 2 == 1) begin
        send_random(8'($urandom_range(0, 255)));
      end
    end else if (pick < 70) begin
      send_random(ESC_INTRO);
      send_random(ESC_EOL);
    end else if (pick < 85) begin
      send_random(ESC_INTRO);
      send_random(ESC_DELTA);
      send_random(8'($urandom_range(0, 255)));
      send_random(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++) begin
        send_random(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // A result may still be in the row-wrap unit when the last one has arrived.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_segments.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_row_width(input logic [11:0] width);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= width;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    line_w = width;
  endtask

  function automatic int field_mismatch(string name, logic [11:0] e, logic [11:0] a);
    if (e !== a) begin
      $error("%s: expected %0d, actual %0d", name, e, a);
      return 1;
    end
    return 0;
  endfunction

  initial begin : result_monitor
    segment_t got;
    segment_t exp_seg;
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.kind        = m_tuser;
        got.row         = m_tdata[11:0];
        got.column      = m_tdata[23:12];
        got.length      = m_tdata[31:24];
        got.color_index = m_tdata[39:32];
        got.last        = m_tlast;
        if (pending_segments.size() == 0) begin
          $error("unexpected result: kind %0d row %0d column %0d length %0d",
                 got.kind, got.row, got.column, got.length);
          fails++;
        end else begin
          exp_seg = pending_segments.pop_front();
          fails += field_mismatch("kind", exp_seg.kind, got.kind);
          fails += field_mismatch("row", exp_seg.row, got.row);
          fails += field_mismatch("column", exp_seg.column, got.column);
          fails += field_mismatch("length", exp_seg.length, got.length);
          fails += field_mismatch("color_index", exp_seg.color_index, got.color_index);
          fails += field_mismatch("last", exp_seg.last, got.last);
        end
      end
      if (hold_left == 0 && hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  initial begin : stimulus
    logic [11:0] width;
    int phase_start;
    ph           = PH_FIRST;
    held_count   = '0;
    literal_left = '0;
    pad_pending  = 1'b0;
    cur_column   = '0;
    cur_row      = '0;
    held_dx      = '0;
    finished     = 1'b0;
    line_w       = ROW_WIDTH_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (OPENING_ROWS[i]) begin
      send_code(OPENING_ROWS[i].code, OPENING_ROWS[i].typed, OPENING_ROWS[i].seg);
    end

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      width = (p == 4) ? 12'($urandom_range(17, 4094)) : PHASE_WIDTHS[p];
      write_row_width(width);
      idle_pct = (p == 2) ? 0 : IDLE_PCT;
      if (p == 5) begin
        // Push both column and row into saturation before drawing there.
        for (int k = 0; k < 20; k++) begin
          send_random(ESC_INTRO);
          send_random(ESC_DELTA);
          send_random(8'hFF);
          send_random(8'hFF);
        end
      end
      phase_start = random_sent;
      while (random_sent < phase_start + PHASE_ITEMS) begin
        if (p == 1 && hold_requests == 0 && random_sent >= phase_start + 5) begin
          hold_requests++;
        end
        send_sequence();
      end
    end

    while (ph != PH_FIRST) begin
      send_random((ph == PH_ESCAPE) ? ESC_EOL : 8'($urandom_range(0, 255)));
    end
    send_code(ESC_INTRO, 1'b0, '0);
    send_code(ESC_EOB, 1'b0, '0);
    for (int k = 0; k < 8; k++) begin
      send_code(8'($urandom_range(0, 255)), 1'b0, '0);
    end

    s_tvalid <= 1'b0;
    while (pending_segments.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("** bmp_rle8_line_decoder: PASSED **");
    end else begin
      $display("** bmp_rle8_line_decoder: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/rle8_pkg.sv
src/bmp_rle8_line_decoder.sv
test/bmp_rle8_line_decoder_tb.sv
